// ===== rtl/bc2d_pkg.sv =====
// Shared types, codes and helper functions of the BC2 block decoder.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bc2d_pkg;

	localparam int MaxSideDefault = 16384;
	localparam int QueueDepthDefault = 2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

	// Channel orders, first named channel in the lowest byte.
	localparam logic [1:0] FMT_BGRA = 2'd0;
	localparam logic [1:0] FMT_RGBA = 2'd1;
	localparam logic [1:0] FMT_ARGB = 2'd2;
	localparam logic [1:0] FMT_ABGR = 2'd3;

	// One classified block as it waits between the front and back ends.
	typedef struct packed {
		logic [15:0]      mask;      // texels that lie inside the image
		logic [13:0]      base_x;
		logic [13:0]      base_y;
		logic [63:0]      alpha;
		logic [31:0]      indices;
		logic [3:0][23:0] palette;   // {r, g, b} for each palette index
	} bc2d_entry_t;

	// Rounded expansion (c * 255 + 15) / 31; the division is a reciprocal multiply
	// that stays exact over the whole 5-bit range.
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [25:0] p;
		p = (26'(c) * 26'd255 + 26'd15) * 26'd8457;
		return p[25:18];
	endfunction

	// Rounded expansion (c * 255 + 31) / 63, again through an exact reciprocal.
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [27:0] p;
		p = (28'(c) * 28'd255 + 28'd31) * 28'd16645;
		return p[27:20];
	endfunction

	// Floor division by three through a reciprocal; exact for x up to 765.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'd683;
		return p[18:11];
	endfunction

	function automatic logic [31:0] pack_pixel(input logic [1:0] fmt, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
		logic [31:0] px;
		case (fmt)
			FMT_RGBA: px = {a, b, g, r};
			FMT_ARGB: px = {b, g, r, a};
			FMT_ABGR: px = {r, g, b, a};
			default:  px = {a, r, g, b};
		endcase
		return px;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bc2d_front.sv =====
// Front end of the BC2 decoder: accepts blocks, expands the palette, works
// out which texels are inside the image and tracks the block position.
// Depends on bc2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bc2d_front
	import bc2d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [14:0] width,
	input  wire logic [14:0] height,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] alpha_bits,
	input  wire logic [15:0] color0,
	input  wire logic [15:0] color1,
	input  wire logic [31:0] color_indices,
	input  wire logic        q_ready,
	output logic             q_push,
	output bc2d_entry_t      q_entry
);

	logic [11:0] block_col_q;
	logic [11:0] block_row_q;
	logic [13:0] xblocks;
	logic [13:0] yblocks;
	logic [12:0] next_col;
	logic [12:0] next_row;
	logic [7:0]  r0, r1, g0, g1, b0, b1;
	logic [13:0] base_x;
	logic [13:0] base_y;
	logic [3:0]  col_in;
	logic [3:0]  row_in;
	logic [15:0] mask;

	assign in_stall = ~q_ready;
	assign q_push   = in_valid & q_ready;

	assign xblocks = 14'((16'(width) + 16'd3) >> 2);
	assign yblocks = 14'((16'(height) + 16'd3) >> 2);
	assign next_col = 13'(block_col_q) + 13'd1;
	assign next_row = 13'(block_row_q) + 13'd1;

	assign base_x = {block_col_q, 2'b00};
	assign base_y = {block_row_q, 2'b00};

	assign r0 = expand5(color0[15:11]);
	assign g0 = expand6(color0[10:5]);
	assign b0 = expand5(color0[4:0]);
	assign r1 = expand5(color1[15:11]);
	assign g1 = expand6(color1[10:5]);
	assign b1 = expand5(color1[4:0]);

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			col_in[j] = {1'b0, base_x + 14'(j)} < width;
			row_in[j] = {1'b0, base_y + 14'(j)} < height;
		end
		for (int i = 0; i < 16; i++) begin
			mask[i] = col_in[i % 4] & row_in[i / 4];
		end
	end

	assign q_entry.mask    = mask;
	assign q_entry.base_x  = base_x;
	assign q_entry.base_y  = base_y;
	assign q_entry.alpha   = alpha_bits;
	assign q_entry.indices = color_indices;
	assign q_entry.palette[0] = {r0, g0, b0};
	assign q_entry.palette[1] = {r1, g1, b1};
	assign q_entry.palette[2] = {div3({r0, 1'b0} + 10'(r1)), div3({g0, 1'b0} + 10'(g1)),
		div3({b0, 1'b0} + 10'(b1))};
	assign q_entry.palette[3] = {div3(10'(r0) + {r1, 1'b0}), div3(10'(g0) + {g1, 1'b0}),
		div3(10'(b0) + {b1, 1'b0})};

	// The position advances for every block, even one lying outside the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_col_q <= '0;
			block_row_q <= '0;
		end else if (q_push) begin
			if ({1'b0, next_col} >= xblocks) begin
				block_col_q <= '0;
				block_row_q <= ({1'b0, next_row} >= yblocks) ? 12'd0 : next_row[11:0];
			end else begin
				block_col_q <= next_col[11:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bc2d_queue.sv =====
// Short queue of classified blocks between the front and back ends.
// Depends on bc2d_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module bc2d_queue
	import bc2d_pkg::*;
#(
	parameter int DEPTH = QueueDepthDefault
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire bc2d_entry_t push_entry,
	output logic       ready,
	input  wire logic  pop,
	output logic       head_valid,
	output bc2d_entry_t head_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bc2d_entry_t     slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign ready      = count_q < CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = slots_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bc2d_back.sv =====
// Back end of the BC2 decoder: walks the inside texels of one block, one per
// cycle while the output is not stalled, into a registered output stage. Depends on bc2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bc2d_back
	import bc2d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  pixel_format,
	input  wire logic        head_valid,
	input  wire bc2d_entry_t head_entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel,
	output logic [13:0]      pos_x,
	output logic [13:0]      pos_y,
	output logic             last_of_block
);

	bc2d_entry_t cur_q;
	logic [15:0] mask_q;
	logic        out_valid_q;
	logic [31:0] pixel_q;
	logic [13:0] pos_x_q;
	logic [13:0] pos_y_q;
	logic        last_q;

	logic        can_emit;
	logic        emit;
	logic        cur_done;
	logic [15:0] rest_mask;
	logic [3:0]  sel;
	logic [1:0]  pal_idx;
	logic [3:0]  alpha_code;
	logic [23:0] rgb;

	assign can_emit  = ~out_valid_q | ~out_stall;
	assign emit      = (mask_q != '0) & can_emit;
	assign rest_mask = mask_q & (mask_q - 16'd1);
	assign cur_done  = (mask_q == '0) | (emit & (rest_mask == '0));
	assign pop       = head_valid & cur_done;

	// Lowest texel that is still to be sent.
	always_comb begin
		sel = '0;
		for (int i = 15; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = 4'(i);
			end
		end
	end

	assign pal_idx    = cur_q.indices[{sel, 1'b0} +: 2];
	assign alpha_code = cur_q.alpha[{sel, 2'b00} +: 4];
	assign rgb        = cur_q.palette[pal_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head_entry.mask;
			end else if (emit) begin
				mask_q <= rest_mask;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_entry;
		end
		if (emit) begin
			pixel_q <= pack_pixel(pixel_format, rgb[23:16], rgb[15:8], rgb[7:0],
				{alpha_code, alpha_code});
			pos_x_q <= cur_q.base_x + 14'(sel[1:0]);
			pos_y_q <= cur_q.base_y + 14'(sel[3:2]);
			last_q  <= rest_mask == '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel         = pixel_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign last_of_block = last_q;

endmodule

`default_nettype wire

// ===== rtl/bc2_texture_block_decoder.sv =====
// Top level of the BC2 (DXT3) texture block decoder: configuration registers,
// front end, block queue and back end. Depends on bc2d_pkg and all bc2d_ modules.
//
// Blocks of 16 bytes enter in raster block order and come out as 32-bit
// texels, one transaction per texel, with their image position; texels past
// the right or bottom edge are dropped and the last texel sent for a block is
// flagged. The back end sends one texel per cycle while the output is not
// stalled. The front end takes a new block each cycle while the two-entry
// block queue has room, so input and output stall independently; the first
// texel of a block passes through the queue, the back end's current-block
// register and the output register. Configuration should be written only
// while no block is in flight.
`timescale 1ns / 1ps
`default_nettype none

module bc2_texture_block_decoder
	import bc2d_pkg::*;
#(
	parameter int MAX_SIDE    = MaxSideDefault,
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] alpha_bits,
	input  wire logic [15:0] color0,
	input  wire logic [15:0] color1,
	input  wire logic [31:0] color_indices,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel,
	output logic [13:0]      pos_x,
	output logic [13:0]      pos_y,
	output logic             last_of_block
);

	logic [1:0]  pixel_format_q;
	logic [14:0] image_width_q;
	logic [14:0] image_height_q;
	logic [14:0] width;
	logic [14:0] height;

	logic        q_ready;
	logic        q_push;
	bc2d_entry_t q_entry;
	logic        q_pop;
	logic        head_valid;
	bc2d_entry_t head_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_BGRA;
			image_width_q  <= 15'd1024;
			image_height_q <= 15'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data[1:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero size counts as one; sizes above the maximum side saturate.
	always_comb begin
		if (image_width_q == '0) begin
			width = 15'd1;
		end else if (int'(image_width_q) > MAX_SIDE) begin
			width = 15'(MAX_SIDE);
		end else begin
			width = image_width_q;
		end
		if (image_height_q == '0) begin
			height = 15'd1;
		end else if (int'(image_height_q) > MAX_SIDE) begin
			height = 15'(MAX_SIDE);
		end else begin
			height = image_height_q;
		end
	end

	bc2d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.width         (width),
		.height        (height),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.alpha_bits    (alpha_bits),
		.color0        (color0),
		.color1        (color1),
		.color_indices (color_indices),
		.q_ready       (q_ready),
		.q_push        (q_push),
		.q_entry       (q_entry)
	);

	bc2d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.ready      (q_ready),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	bc2d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel_format  (pixel_format_q),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel         (pixel),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.last_of_block (last_of_block)
	);

endmodule

`default_nettype wire

// ===== dv/bc2_texel_checker.sv =====
// Texel checker for the BC2 block decoder: snoops configuration writes and both channels,
// predicts the texels of every accepted block and compares them in order.
// Depends on bc2d_pkg for register indexes and channel-order codes.
`timescale 1ns / 1ps

module bc2_texel_checker
	import bc2d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [63:0] alpha_bits,
	input  wire logic [15:0] color0,
	input  wire logic [15:0] color1,
	input  wire logic [31:0] color_indices,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [31:0] pixel,
	input  wire logic [13:0] pos_x,
	input  wire logic [13:0] pos_y,
	input  wire logic        last_of_block,
	output int               mismatches,
	output int               pending,
	output int               texels_checked
);

	localparam int unsigned SIDE_LIMIT = 16384;

	typedef struct packed {
		logic [31:0] pixel;
		logic [13:0] x;
		logic [13:0] y;
		logic        last;
	} texel_t;

	texel_t      texel_q[$];
	logic [1:0]  fmt_q;
	int unsigned width_q;
	int unsigned height_q;
	int unsigned col_q;
	int unsigned row_q;

	function automatic int unsigned clamp_side(input int unsigned v);
		if (v == 0) return 1;
		if (v > SIDE_LIMIT) return SIDE_LIMIT;
		return v;
	endfunction

	function automatic int unsigned widen5(input int unsigned c);
		return (c * 255 + 15) / 31;
	endfunction

	function automatic int unsigned widen6(input int unsigned c);
		return (c * 255 + 31) / 63;
	endfunction

	// Four-color palette: the two endpoints and the truncated thirds between them.
	function automatic int unsigned blend(input int unsigned e0, input int unsigned e1,
			input logic [1:0] sel);
		case (sel)
			2'd0: return e0;
			2'd1: return e1;
			2'd2: return (2 * e0 + e1) / 3;
			default: return (e0 + 2 * e1) / 3;
		endcase
	endfunction

	function automatic logic [31:0] arrange(input logic [1:0] fmt, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
		case (fmt)
			FMT_RGBA: return {a, b, g, r};
			FMT_ARGB: return {b, g, r, a};
			FMT_ABGR: return {r, g, b, a};
			default:  return {a, r, g, b};
		endcase
	endfunction

	task automatic decode_block(input logic [63:0] abits, input logic [15:0] c0,
			input logic [15:0] c1, input logic [31:0] ibits);
		int unsigned w, h, r0, r1, g0, g1, b0, b1, x, y, last_i, nxt;
		logic [1:0]  sel;
		logic [7:0]  a;
		bit          in_image [16];
		texel_t      t;
		w = clamp_side(width_q);
		h = clamp_side(height_q);
		r0 = widen5(c0[15:11]);
		r1 = widen5(c1[15:11]);
		g0 = widen6(c0[10:5]);
		g1 = widen6(c1[10:5]);
		b0 = widen5(c0[4:0]);
		b1 = widen5(c1[4:0]);
		last_i = 16;
		for (int i = 0; i < 16; i++) begin
			in_image[i] = (col_q * 4 + i % 4 < w) && (row_q * 4 + i / 4 < h);
			if (in_image[i])
				last_i = i;
		end
		for (int i = 0; i < 16; i++) begin
			if (in_image[i]) begin
				x = col_q * 4 + i % 4;
				y = row_q * 4 + i / 4;
				sel = ibits[2 * i +: 2];
				a = 8'(abits[4 * i +: 4] * 17);
				t.pixel = arrange(fmt_q, 8'(blend(r0, r1, sel)), 8'(blend(g0, g1, sel)),
					8'(blend(b0, b1, sel)), a);
				t.x = 14'(x);
				t.y = 14'(y);
				t.last = (i == last_i);
				texel_q.push_back(t);
			end
		end
		// Raster walk over blocks; it wraps to the top once the last row is done.
		nxt = col_q + 1;
		if (nxt >= (w + 3) / 4) begin
			col_q = 0;
			nxt = row_q + 1;
			row_q = (nxt >= (h + 3) / 4) ? 0 : (nxt & 12'hFFF);
		end else begin
			col_q = nxt & 12'hFFF;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		texel_t want;
		if (!arst_n) begin
			fmt_q = FMT_BGRA;
			width_q = 1024;
			height_q = 1024;
			col_q = 0;
			row_q = 0;
			texel_q.delete();
			mismatches = 0;
			pending = 0;
			texels_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PIXEL_FORMAT: fmt_q = cfg_data[1:0];
					CFG_IMAGE_WIDTH:  width_q = cfg_data;
					CFG_IMAGE_HEIGHT: height_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_block(alpha_bits, color0, color1, color_indices);
			if (out_valid && !out_stall) begin
				if (texel_q.size() == 0) begin
					$error("texel at (%0d, %0d) arrived with no block outstanding", pos_x, pos_y);
					mismatches++;
				end else begin
					want = texel_q.pop_front();
					texels_checked++;
					if (pixel !== want.pixel) begin
						$error("pixel: expected %h, got %h", want.pixel, pixel);
						mismatches++;
					end
					if (pos_x !== want.x) begin
						$error("pos_x: expected %0d, got %0d", want.x, pos_x);
						mismatches++;
					end
					if (pos_y !== want.y) begin
						$error("pos_y: expected %0d, got %0d", want.y, pos_y);
						mismatches++;
					end
					if (last_of_block !== want.last) begin
						$error("last_of_block: expected %b, got %b", want.last, last_of_block);
						mismatches++;
					end
				end
			end
			pending = texel_q.size();
		end
	end

endmodule

// ===== dv/bc2_texture_block_decoder_tb.sv =====
// Top of the BC2 block decoder testbench: clock, reset, block stimulus, output stalls
// and the verdict. Depends on bc2d_pkg, bc2_texture_block_decoder and bc2_texel_checker.
`timescale 1ns / 1ps

module bc2_texture_block_decoder_tb
	import bc2d_pkg::*;
;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] alpha_bits;
	logic [15:0] color0;
	logic [15:0] color1;
	logic [31:0] color_indices;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] pixel;
	logic [13:0] pos_x;
	logic [13:0] pos_y;
	logic        last_of_block;

	int mismatches;
	int pending;
	int texels_checked;
	int blocks_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #4 clk = ~clk;

	bc2_texture_block_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.alpha_bits    (alpha_bits),
		.color0        (color0),
		.color1        (color1),
		.color_indices (color_indices),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel         (pixel),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.last_of_block (last_of_block)
	);

	bc2_texel_checker u_texel_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.alpha_bits     (alpha_bits),
		.color0         (color0),
		.color1         (color1),
		.color_indices  (color_indices),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel          (pixel),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.last_of_block  (last_of_block),
		.mismatches     (mismatches),
		.pending        (pending),
		.texels_checked (texels_checked)
	);

	// Mostly small images so blocks get clipped at both edges, with the odd extreme.
	function automatic int random_side();
		case ($urandom_range(19))
			0: return 0;
			1: return 32767;
			2: return 16384;
			3: return $urandom_range(32767);
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	task automatic set_image(input logic [1:0] fmt, input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PIXEL_FORMAT;
		cfg_data <= {13'($urandom), fmt};
		@(posedge clk);
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= 15'(w);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= 15'(h);
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= 15'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_block(input logic [63:0] abits, input logic [15:0] c0,
			input logic [15:0] c1, input logic [31:0] ibits, input int gap_pct);
		in_valid <= 1'b1;
		alpha_bits <= abits;
		color0 <= c0;
		color1 <= c1;
		color_indices <= ibits;
		do
			@(posedge clk);
		while (in_stall);
		blocks_sent++;
		if (!quiet && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int gap_pct);
		logic [63:0] abits;
		logic [15:0] c0, c1;
		logic [31:0] ibits;
		abits = {$urandom, $urandom};
		c0 = 16'($urandom);
		c1 = 16'($urandom);
		ibits = $urandom;
		case ($urandom_range(9))
			0: c1 = c0;
			1: begin
				c0 = 16'hFFFF;
				c1 = 16'h0000;
			end
			2: abits = '1;
			default: ;
		endcase
		send_block(abits, c0, c1, ibits, gap_pct);
	endtask

	// Lets every outstanding texel drain, plus slack for blocks that yield none.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_image(input logic [1:0] fmt, input int w, input int h, input int blocks);
		int gap_pct;
		gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
		set_image(fmt, w, h);
		repeat (blocks) send_random(gap_pct);
		settle();
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PIXEL_FORMAT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		alpha_bits <= '0;
		color0 <= '0;
		color1 <= '0;
		color_indices <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every block of a 1024 x 1024 image is whole.
		send_block(64'h0, 16'h0000, 16'h0000, 32'h0000_0000, 20);
		send_block('1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 20);
		send_block(64'hFEDC_BA98_7654_3210, 16'hF800, 16'h07E0, 32'hE4E4_E4E4, 20);
		send_block(64'h0123_4567_89AB_CDEF, 16'h001F, 16'hF800, 32'h1B1B_1B1B, 20);
		send_block(64'h0, 16'hFFFF, 16'h0000, 32'h5555_5555, 20);
		send_block('1, 16'h0000, 16'hFFFF, 32'hAAAA_AAAA, 20);
		send_block(64'hF0F0_F0F0_0F0F_0F0F, 16'h7BEF, 16'h7BEF, 32'hE4E4_E4E4, 20);
		send_block(64'h5A5A_A5A5_5A5A_A5A5, 16'h0841, 16'hF7BE, 32'h4E4E_4E4E, 20);
		send_block(64'h8888_8888_8888_8888, 16'h07E0, 16'h001F, 32'hB1B1_B1B1, 20);
		send_block(64'h1111_1111_1111_1111, 16'hFFE0, 16'h001F, 32'h3333_CCCC, 20);
		repeat (6) send_random(20);
		settle();

		// Edge clipping, clamped sizes and blocks left outside the image.
		run_image(FMT_RGBA, 6, 5, 12);
		run_image(FMT_ARGB, 0, 0, 6);
		hold_req = 1'b1;
		run_image(FMT_ABGR, 32767, 32767, 20);
		run_image(FMT_BGRA, 40, 13, 20);
		run_image(FMT_RGBA, 8, 8, 6);
		run_image(FMT_ARGB, 16384, 1, 6);
		run_image(FMT_ABGR, 1, 16384, 6);

		while (blocks_sent < 170)
			run_image(2'($urandom), random_side(), random_side(), $urandom_range(8, 30));

		quiet = 1'b1;
		run_image(2'($urandom), $urandom_range(1, 24), $urandom_range(1, 24), 20);

		$display("Sent %0d blocks under %0d image settings and checked %0d texels.",
			blocks_sent, settings_used, texels_checked);
		$display("Run covered all channel orders, clipped and clamped sizes and a long output stall.");
		if (mismatches == 0)
			$display("bc2_texture_block_decoder_tb OK");
		else
			$display("bc2_texture_block_decoder_tb NOT OK");
		$finish;
	end

	initial begin : receiver
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req && !hold_done) begin
				// Long hold-off so the block queue fills and the input side backs up.
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (quiet || $urandom_range(99) >= 30) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("bc2_texture_block_decoder_tb NOT OK");
			$finish;
		end
	end

endmodule
